@@ hdl/mtcp_pkg.sv @@
// Shared types, codes and result builders for the MIDI track chunk parser.
package mtcp_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    localparam logic [31:0] TagMtrk   = 32'h4d54726b;
    localparam logic [7:0]  StSysex   = 8'hf0;
    localparam logic [7:0]  StEscape  = 8'hf7;
    localparam logic [7:0]  StMeta    = 8'hff;
    localparam logic [7:0]  MtSeqNum  = 8'h00;
    localparam logic [7:0]  MtEot     = 8'h2f;
    localparam logic [7:0]  MtTempo   = 8'h51;
    localparam logic [7:0]  MtSmpte   = 8'h54;
    localparam logic [7:0]  MtTimeSig = 8'h58;
    localparam logic [7:0]  MtKeySig  = 8'h59;

    typedef enum logic [4:0] {
        K_TRACK_START = 5'd0,  K_NOTE = 5'd1, K_POLY = 5'd2, K_CONTROL = 5'd3,
        K_PROGRAM = 5'd4, K_CHAN_PRESS = 5'd5, K_BEND = 5'd6, K_SYSEX = 5'd7,
        K_SEQNUM = 5'd8, K_TEXT = 5'd9, K_EOT = 5'd10, K_TEMPO = 5'd11,
        K_SMPTE = 5'd12, K_TIMESIG = 5'd13, K_KEYSIG = 5'd14,
        K_TRACK_END = 5'd15, K_ERROR = 5'd16
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE = 3'd0, E_NO_TAG = 3'd1, E_SYSEX_CONT = 3'd2,
        E_NO_STATUS = 3'd3, E_BAD_STATUS = 3'd4
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  channel;
        logic [7:0]  first_data;
        logic [6:0]  second_data;
        logic        has_data;
        logic [39:0] meta_value;
        logic [7:0]  meta_type;
        logic [31:0] event_ticks;
        t_err        error_code;
        logic        last;
    } t_res;

    function automatic t_res mk(t_kind k, logic [31:0] ticks);
        t_res r;
        r = '0;
        r.kind = k;
        r.event_ticks = ticks;
        return r;
    endfunction

    function automatic t_res err_res(t_err e, logic [31:0] ticks);
        t_res r;
        r = mk(K_ERROR, ticks);
        r.error_code = e;
        return r;
    endfunction

    function automatic t_res chan_res(logic [7:0] rs, logic [4:0] ch, logic [7:0] d1,
                                      logic [6:0] d2, logic [31:0] ticks);
        t_res r;
        r = mk(K_NOTE, ticks);
        r.channel = ch;
        r.first_data = d1;
        r.second_data = d2;
        r.has_data = 1'b1;
        case (rs[7:4])
            4'h8: r.second_data = '0;
            4'hA: r.kind = K_POLY;
            4'hB: r.kind = K_CONTROL;
            4'hC: begin
                r.kind = K_PROGRAM;
                r.has_data = 1'b0;
                r.second_data = '0;
            end
            4'hD: begin
                r.kind = K_CHAN_PRESS;
                r.has_data = 1'b0;
                r.second_data = '0;
            end
            4'hE: r.kind = K_BEND;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic meta_known(logic [7:0] mt);
        return mt == MtSeqNum || mt == MtEot || mt == MtTempo || mt == MtSmpte ||
               mt == MtTimeSig || mt == MtKeySig;
    endfunction

    function automatic t_res meta_res(logic [7:0] mt, logic [39:0] v, logic [31:0] ticks);
        t_res r;
        r = mk(K_EOT, ticks);
        unique case (mt)
            MtSeqNum: begin
                r.kind = K_SEQNUM;
                r.meta_value = {24'd0, v[15:0]};
            end
            MtTempo: begin
                r.kind = K_TEMPO;
                r.meta_value = {16'd0, v[23:0]};
            end
            MtSmpte: begin
                r.kind = K_SMPTE;
                r.meta_value = {1'b0, v[38:0]};
            end
            MtTimeSig: begin
                r.kind = K_TIMESIG;
                r.meta_value = {8'd0, v[31:0]};
            end
            MtKeySig: begin
                r.kind = K_KEYSIG;
                r.meta_value = {24'd0, v[15:0]};
            end
            default: ;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/mtcp_if.sv @@
// Byte and event channel interfaces.
interface mtcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_start;
    modport source (output valid, data_byte, chunk_start, input ready);
    modport sink (input valid, data_byte, chunk_start, output ready);
endinterface

interface mtcp_event_if;
    logic        valid;
    logic        ready;
    logic [4:0]  kind;
    logic [4:0]  channel;
    logic [7:0]  first_data;
    logic [6:0]  second_data;
    logic        has_data;
    logic [39:0] meta_value;
    logic [7:0]  meta_type;
    logic [31:0] event_ticks;
    logic [2:0]  error_code;
    logic        last;
    modport source (output valid, kind, channel, first_data, second_data, has_data,
                    meta_value, meta_type, event_ticks, error_code, last, input ready);
    modport sink (input valid, kind, channel, first_data, second_data, has_data,
                  meta_value, meta_type, event_ticks, error_code, last, output ready);
endinterface

@@ hdl/mtcp_front.sv @@
// Byte classifier and parse state: turns one byte into up to two events.
module mtcp_front
    import mtcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    output logic [1:0] o_push_cnt,
    output t_res       o_res0,
    output t_res       o_res1
);

    typedef enum logic [18:0] {
        P_WAIT      = 19'h00001, P_TAG1     = 19'h00002, P_TAG2    = 19'h00004,
        P_TAG3      = 19'h00008, P_LEN0     = 19'h00010, P_LEN1    = 19'h00020,
        P_LEN2      = 19'h00040, P_LEN3     = 19'h00080, P_DELTA   = 19'h00100,
        P_STATUS    = 19'h00200, P_DATA1    = 19'h00400, P_DATA2   = 19'h00800,
        P_SX_LEN    = 19'h01000, P_SX_DATA  = 19'h02000, P_META_TYPE = 19'h04000,
        P_META_LEN  = 19'h08000, P_META_DATA = 19'h10000, P_DONE   = 19'h20000,
        P_HALT      = 19'h40000
    } t_phase;

    localparam logic [18:0] BodyMask = 19'h1ff00;

    t_phase      r_phase, n_phase;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [31:0] r_varlen, n_varlen;
    logic [7:0]  r_rs, n_rs;
    logic [4:0]  r_chan, n_chan;
    logic        r_sxp, n_sxp;
    logic [31:0] r_tick, n_tick;
    logic [39:0] r_fs, n_fs;
    logic [31:0] r_pl, n_pl;
    logic [7:0]  r_meta, n_meta;
    logic [4:0]  r_sel;

    t_res        res [2];
    logic [1:0]  cnt;
    logic        fin;
    logic        pass;
    logic [31:0] va;
    logic [31:0] pl_dec;
    logic        is_text;

    always_comb begin
        n_phase = r_phase;
        n_bytes_left = r_bytes_left;
        n_varlen = r_varlen;
        n_rs = r_rs;
        n_chan = r_chan;
        n_sxp = r_sxp;
        n_tick = r_tick;
        n_fs = r_fs;
        n_pl = r_pl;
        n_meta = r_meta;
        res[0] = '0;
        res[1] = '0;
        cnt = '0;
        fin = 1'b0;
        pass = (r_sel == 5'd0) || (r_sel == r_chan);
        va = {r_varlen[24:0], i_byte[6:0]};
        pl_dec = r_pl - 32'd1;
        is_text = (r_meta >= 8'h01) && (r_meta <= 8'h0f);
        if (i_start) begin
            n_phase = P_TAG1;
            n_bytes_left = '0;
            n_varlen = '0;
            n_rs = '0;
            n_chan = '0;
            n_sxp = 1'b0;
            n_tick = '0;
            n_fs = {32'd0, i_byte};
            n_pl = '0;
            n_meta = '0;
        end else begin
            if (|(r_phase & BodyMask) && r_bytes_left != 32'd0) begin
                n_bytes_left = r_bytes_left - 32'd1;
            end
            unique case (r_phase)
                P_TAG1, P_TAG2: begin
                    n_fs = {r_fs[31:0], i_byte};
                    n_phase = (r_phase == P_TAG1) ? P_TAG2 : P_TAG3;
                end
                P_TAG3: begin
                    if ({r_fs[23:0], i_byte} == TagMtrk) begin
                        n_phase = P_LEN0;
                        n_bytes_left = '0;
                        n_fs = '0;
                    end else begin
                        n_fs = {r_fs[31:0], i_byte};
                        res[cnt[0]] = err_res(E_NO_TAG, r_tick);
                        cnt = cnt + 2'd1;
                        n_phase = P_HALT;
                    end
                end
                P_LEN0, P_LEN1, P_LEN2: begin
                    n_bytes_left = {r_bytes_left[23:0], i_byte};
                    n_phase = (r_phase == P_LEN0) ? P_LEN1 :
                              (r_phase == P_LEN1) ? P_LEN2 : P_LEN3;
                end
                P_LEN3: begin
                    n_bytes_left = {r_bytes_left[23:0], i_byte};
                    res[cnt[0]] = mk(K_TRACK_START, r_tick);
                    cnt = cnt + 2'd1;
                    fin = 1'b1;
                end
                P_DELTA: begin
                    n_varlen = va;
                    if (!i_byte[7]) begin
                        n_tick = r_tick + va;
                        n_phase = P_STATUS;
                    end
                end
                P_STATUS: begin
                    if (r_sxp && i_byte != StEscape) begin
                        res[cnt[0]] = err_res(E_SYSEX_CONT, r_tick);
                        cnt = cnt + 2'd1;
                        n_phase = P_HALT;
                    end else if (!i_byte[7]) begin
                        if (!r_rs[7]) begin
                            res[cnt[0]] = err_res(E_NO_STATUS, r_tick);
                            cnt = cnt + 2'd1;
                            n_phase = P_HALT;
                        end else if (r_rs[7:5] == 3'b110) begin
                            if (pass) begin
                                res[cnt[0]] = chan_res(r_rs, r_chan, i_byte, 7'd0, r_tick);
                                cnt = cnt + 2'd1;
                            end
                            fin = 1'b1;
                        end else begin
                            n_fs = {32'd0, i_byte};
                            n_phase = P_DATA2;
                        end
                    end else if (i_byte < StSysex) begin
                        n_rs = {i_byte[7:4], 4'd0};
                        n_chan = {1'b0, i_byte[3:0]} + 5'd1;
                        n_phase = P_DATA1;
                    end else if (i_byte == StSysex || i_byte == StEscape) begin
                        n_rs = '0;
                        n_meta = i_byte;
                        n_varlen = '0;
                        n_phase = P_SX_LEN;
                    end else if (i_byte == StMeta) begin
                        n_rs = '0;
                        n_phase = P_META_TYPE;
                    end else begin
                        res[cnt[0]] = err_res(E_BAD_STATUS, r_tick);
                        cnt = cnt + 2'd1;
                        n_phase = P_HALT;
                    end
                end
                P_DATA1: begin
                    if (r_rs[7:5] == 3'b110) begin
                        if (pass) begin
                            res[cnt[0]] = chan_res(r_rs, r_chan, i_byte, 7'd0, r_tick);
                            cnt = cnt + 2'd1;
                        end
                        fin = 1'b1;
                    end else begin
                        n_fs = {32'd0, i_byte};
                        n_phase = P_DATA2;
                    end
                end
                P_DATA2: begin
                    if (pass) begin
                        res[cnt[0]] = chan_res(r_rs, r_chan, r_fs[7:0], i_byte[6:0], r_tick);
                        cnt = cnt + 2'd1;
                    end
                    fin = 1'b1;
                end
                P_SX_LEN: begin
                    n_varlen = va;
                    if (!i_byte[7]) begin
                        n_pl = va;
                        if (va == 32'd0) begin
                            n_sxp = (r_meta == StSysex || r_sxp) && r_meta != StEscape;
                            fin = 1'b1;
                        end else begin
                            n_phase = P_SX_DATA;
                        end
                    end
                end
                P_SX_DATA: begin
                    n_pl = pl_dec;
                    res[cnt[0]] = mk(K_SYSEX, r_tick);
                    res[cnt[0]].first_data = i_byte;
                    res[cnt[0]].last = (pl_dec == 32'd0);
                    cnt = cnt + 2'd1;
                    if (pl_dec == 32'd0) begin
                        n_sxp = (r_meta == StSysex || r_sxp) && i_byte != StEscape;
                        fin = 1'b1;
                    end
                end
                P_META_TYPE: begin
                    n_meta = i_byte;
                    n_varlen = '0;
                    n_phase = P_META_LEN;
                end
                P_META_LEN: begin
                    n_varlen = va;
                    if (!i_byte[7]) begin
                        n_pl = va;
                        n_fs = '0;
                        if (va != 32'd0) begin
                            n_phase = P_META_DATA;
                        end else begin
                            if (is_text) begin
                                res[cnt[0]] = mk(K_TEXT, r_tick);
                                res[cnt[0]].meta_type = r_meta;
                                res[cnt[0]].last = 1'b1;
                                cnt = cnt + 2'd1;
                            end else if (meta_known(r_meta)) begin
                                res[cnt[0]] = meta_res(r_meta, 40'd0, r_tick);
                                cnt = cnt + 2'd1;
                            end
                            fin = 1'b1;
                        end
                    end
                end
                P_META_DATA: begin
                    n_pl = pl_dec;
                    n_fs = {r_fs[31:0], i_byte};
                    if (is_text) begin
                        res[cnt[0]] = mk(K_TEXT, r_tick);
                        res[cnt[0]].first_data = i_byte;
                        res[cnt[0]].has_data = 1'b1;
                        res[cnt[0]].meta_type = r_meta;
                        res[cnt[0]].last = (pl_dec == 32'd0);
                        cnt = cnt + 2'd1;
                        fin = (pl_dec == 32'd0);
                    end else if (pl_dec == 32'd0) begin
                        if (meta_known(r_meta)) begin
                            res[cnt[0]] = meta_res(r_meta, {r_fs[31:0], i_byte}, r_tick);
                            cnt = cnt + 2'd1;
                        end
                        fin = 1'b1;
                    end
                end
                default: ;
            endcase
            // close the event: end the track once the body count is spent
            if (fin) begin
                if (n_bytes_left == 32'd0) begin
                    res[cnt[0]] = mk(K_TRACK_END, r_tick);
                    cnt = cnt + 2'd1;
                    n_phase = P_DONE;
                end else begin
                    n_phase = P_DELTA;
                    n_varlen = '0;
                end
            end
        end
    end

    assign o_push_cnt = i_take ? cnt : 2'd0;
    assign o_res0 = res[0];
    assign o_res1 = res[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_WAIT;
            r_bytes_left <= '0;
            r_varlen <= '0;
            r_rs <= '0;
            r_chan <= '0;
            r_sxp <= 1'b0;
            r_tick <= '0;
            r_fs <= '0;
            r_pl <= '0;
            r_meta <= '0;
            r_sel <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sel <= i_cfg_wdata;
            end
            if (i_take) begin
                r_phase <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_varlen <= n_varlen;
                r_rs <= n_rs;
                r_chan <= n_chan;
                r_sxp <= n_sxp;
                r_tick <= n_tick;
                r_fs <= n_fs;
                r_pl <= n_pl;
                r_meta <= n_meta;
            end
        end
    end

endmodule

@@ hdl/mtcp_queue.sv @@
// Event queue between the parser and the output channel: two pushes, one pop.
module mtcp_queue
    import mtcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_res       i_res0,
    input  t_res       i_res1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_res       o_res
);

    t_res             r_mem [QDepth];
    logic [QAw-1:0]   r_head, r_tail;
    logic [QAw:0]     r_count;
    logic             pop;

    assign o_room  = r_count <= (QAw+1)'(QDepth - 2);
    assign o_valid = r_count != '0;
    assign o_res   = r_mem[r_head];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_tail] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_tail + QAw'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_count <= '0;
        end else begin
            r_tail <= r_tail + QAw'(i_push_cnt);
            if (pop) begin
                r_head <= r_head + QAw'(1);
            end
            r_count <= r_count + (QAw+1)'(i_push_cnt) - (QAw+1)'(pop);
        end
    end

endmodule

@@ hdl/midi_track_chunk_parser.sv @@
// Top level of the MIDI track chunk parser.
//   channel   dir  words
//   i_byte    in   one track byte with chunk-start flag
//   o_event   out  one parsed event, error or payload byte
//   i_cfg_*   in   channel filter register, 5 bits
// One byte per cycle; each byte is parsed in the cycle it is accepted and
// yields zero, one or two events into a four-entry queue.
// Bytes are taken while the queue has room for two events, so a stalled
// output holds the input once three or four events are pending.
// Reset clears the parse state and the filter; no clearing pass.
module midi_track_chunk_parser
    import mtcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    mtcp_byte_if.sink    i_byte,
    mtcp_event_if.source o_event
);

    logic       room;
    logic       take;
    logic [1:0] push_cnt;
    t_res       res0, res1, head;

    assign i_byte.ready = room;
    assign take = i_byte.valid && room;

    mtcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_take     (take),
        .i_byte     (i_byte.data_byte),
        .i_start    (i_byte.chunk_start),
        .o_push_cnt (push_cnt),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    mtcp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_cnt(push_cnt),
        .i_res0    (res0),
        .i_res1    (res1),
        .o_room    (room),
        .o_valid   (o_event.valid),
        .i_ready   (o_event.ready),
        .o_res     (head)
    );

    assign o_event.kind        = head.kind;
    assign o_event.channel     = head.channel;
    assign o_event.first_data  = head.first_data;
    assign o_event.second_data = head.second_data;
    assign o_event.has_data    = head.has_data;
    assign o_event.meta_value  = head.meta_value;
    assign o_event.meta_type   = head.meta_type;
    assign o_event.event_ticks = head.event_ticks;
    assign o_event.error_code  = head.error_code;
    assign o_event.last        = head.last;

endmodule

@@ hdl/mtcp_checker.sv @@
// Port checks for the MIDI track chunk parser, bound to the top level.
module mtcp_checker
    import mtcp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [4:0]  i_kind,
    input logic [4:0]  i_channel,
    input logic [2:0]  i_error_code,
    input logic [31:0] i_event_ticks
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind))
        else $error("event dropped while stalled");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_kind == K_ERROR) == (i_error_code != E_NONE)))
        else $error("error code does not match kind");

    a_start_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == K_TRACK_START |-> i_event_ticks == 32'd0)
        else $error("track start with nonzero ticks");

    a_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_channel != 5'd0 |->
            (i_kind >= K_NOTE && i_kind <= K_BEND))
        else $error("channel on a non-channel event");

endmodule

bind midi_track_chunk_parser mtcp_checker u_mtcp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_event.valid),
    .i_ready      (o_event.ready),
    .i_kind       (o_event.kind),
    .i_channel    (o_event.channel),
    .i_error_code (o_event.error_code),
    .i_event_ticks(o_event.event_ticks)
);

@@ dv/testbench.sv @@
// Self-checking testbench for the MIDI track chunk parser: byte stimulus, event prediction, checks.
module testbench;
    import mtcp_pkg::*;

    typedef enum logic [4:0] {
        PH_WAIT, PH_TAG1, PH_TAG2, PH_TAG3, PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3,
        PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_SX_LEN, PH_SX_DATA,
        PH_META_TYPE, PH_META_LEN, PH_META_DATA, PH_DONE, PH_HALT
    } parse_ph_t;

    localparam int IdleLimit   = 5000;
    localparam int DrainCycles = 8;

    class event_scoreboard;
        t_res        pending[$];
        int          errors;
        int          n_bytes;
        int          n_events;
        logic [4:0]  chan_sel;
        parse_ph_t   phase;
        logic [31:0] left;
        logic [31:0] varlen;
        logic [7:0]  run_status;
        logic [4:0]  chan;
        logic        sx_open;
        logic [31:0] ticks;
        logic [39:0] shift;
        logic [31:0] payload;
        logic [7:0]  cur_meta;

        function new();
            errors = 0;
            n_bytes = 0;
            n_events = 0;
            chan_sel = '0;
            clear_track();
        endfunction

        function void clear_track();
            phase = PH_WAIT;
            left = '0;
            varlen = '0;
            run_status = '0;
            chan = '0;
            sx_open = 1'b0;
            ticks = '0;
            shift = '0;
            payload = '0;
            cur_meta = '0;
        endfunction

        function void set_filter(logic [4:0] v);
            chan_sel = v;
        endfunction

        function t_res blank_event(t_kind k);
            t_res r;
            r = '0;
            r.kind = k;
            r.event_ticks = ticks;
            return r;
        endfunction

        // At most two events per byte; anything beyond is dropped.
        function void emit(ref int n, input t_res r);
            if (n > 1) return;
            pending.push_back(r);
            n++;
        endfunction

        function void halt(ref int n, input t_err e);
            t_res r;
            r = blank_event(K_ERROR);
            r.error_code = e;
            emit(n, r);
            phase = PH_HALT;
        endfunction

        function void end_event(ref int n);
            if (left == 0) begin
                emit(n, blank_event(K_TRACK_END));
                phase = PH_DONE;
            end else begin
                phase = PH_DELTA;
                varlen = '0;
            end
        endfunction

        function void chan_event(ref int n, input logic [7:0] d1, input logic [6:0] d2);
            t_res r;
            r = blank_event(K_NOTE);
            r.channel = chan;
            r.first_data = d1;
            r.second_data = d2;
            r.has_data = 1'b1;
            case (run_status[7:4])
                4'h8: r.second_data = '0;
                4'hA: r.kind = K_POLY;
                4'hB: r.kind = K_CONTROL;
                4'hC: begin
                    r.kind = K_PROGRAM;
                    r.has_data = 1'b0;
                    r.second_data = '0;
                end
                4'hD: begin
                    r.kind = K_CHAN_PRESS;
                    r.has_data = 1'b0;
                    r.second_data = '0;
                end
                4'hE: r.kind = K_BEND;
                default: ;
            endcase
            if (chan_sel == 0 || chan_sel == chan) emit(n, r);
            end_event(n);
        endfunction

        function logic is_text();
            return cur_meta >= 8'h01 && cur_meta <= 8'h0f;
        endfunction

        function void close_meta(ref int n);
            t_res r;
            r = blank_event(K_EOT);
            case (cur_meta)
                MtSeqNum: begin
                    r.kind = K_SEQNUM;
                    r.meta_value = {24'd0, shift[15:0]};
                    emit(n, r);
                end
                MtEot: emit(n, r);
                MtTempo: begin
                    r.kind = K_TEMPO;
                    r.meta_value = {16'd0, shift[23:0]};
                    emit(n, r);
                end
                MtSmpte: begin
                    r.kind = K_SMPTE;
                    r.meta_value = {1'b0, shift[38:0]};
                    emit(n, r);
                end
                MtTimeSig: begin
                    r.kind = K_TIMESIG;
                    r.meta_value = {8'd0, shift[31:0]};
                    emit(n, r);
                end
                MtKeySig: begin
                    r.kind = K_KEYSIG;
                    r.meta_value = {24'd0, shift[15:0]};
                    emit(n, r);
                end
                default: ;
            endcase
            end_event(n);
        endfunction

        function void note_byte(logic [7:0] b, logic cs);
            int   n;
            t_res r;
            n = 0;
            n_bytes++;
            if (cs) begin
                clear_track();
                shift = {32'd0, b};
                phase = PH_TAG1;
                return;
            end
            if (phase >= PH_DELTA && phase <= PH_META_DATA && left != 0) left--;
            case (phase)
                PH_TAG1, PH_TAG2, PH_TAG3: begin
                    shift = {shift[31:0], b};
                    if (phase == PH_TAG3) begin
                        if (shift[31:0] == TagMtrk) begin
                            phase = PH_LEN0;
                            left = '0;
                            shift = '0;
                        end else begin
                            halt(n, E_NO_TAG);
                        end
                    end else begin
                        phase = parse_ph_t'(phase + 1);
                    end
                end
                PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3: begin
                    left = {left[23:0], b};
                    if (phase == PH_LEN3) begin
                        emit(n, blank_event(K_TRACK_START));
                        end_event(n);
                    end else begin
                        phase = parse_ph_t'(phase + 1);
                    end
                end
                PH_DELTA: begin
                    varlen = {varlen[24:0], b[6:0]};
                    if (!b[7]) begin
                        ticks = ticks + varlen;
                        phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (sx_open && b != StEscape) begin
                        halt(n, E_SYSEX_CONT);
                    end else if (!b[7]) begin
                        if (!run_status[7]) halt(n, E_NO_STATUS);
                        else if (run_status[7:5] == 3'b110) chan_event(n, b, 7'd0);
                        else begin
                            shift = {32'd0, b};
                            phase = PH_DATA2;
                        end
                    end else if (b < 8'hf0) begin
                        run_status = {b[7:4], 4'h0};
                        chan = {1'b0, b[3:0]} + 5'd1;
                        phase = PH_DATA1;
                    end else if (b == StSysex || b == StEscape) begin
                        run_status = '0;
                        cur_meta = b;
                        varlen = '0;
                        phase = PH_SX_LEN;
                    end else if (b == StMeta) begin
                        run_status = '0;
                        phase = PH_META_TYPE;
                    end else begin
                        halt(n, E_BAD_STATUS);
                    end
                end
                PH_DATA1: begin
                    if (run_status[7:5] == 3'b110) chan_event(n, b, 7'd0);
                    else begin
                        shift = {32'd0, b};
                        phase = PH_DATA2;
                    end
                end
                PH_DATA2: chan_event(n, shift[7:0], b[6:0]);
                PH_SX_LEN: begin
                    varlen = {varlen[24:0], b[6:0]};
                    if (!b[7]) begin
                        payload = varlen;
                        if (payload == 0) begin
                            sx_open = (cur_meta == StSysex || sx_open) && cur_meta != StEscape;
                            end_event(n);
                        end else begin
                            phase = PH_SX_DATA;
                        end
                    end
                end
                PH_SX_DATA: begin
                    payload--;
                    r = blank_event(K_SYSEX);
                    r.first_data = b;
                    r.last = (payload == 0);
                    emit(n, r);
                    if (payload == 0) begin
                        sx_open = (cur_meta == StSysex || sx_open) && b != StEscape;
                        end_event(n);
                    end
                end
                PH_META_TYPE: begin
                    cur_meta = b;
                    varlen = '0;
                    phase = PH_META_LEN;
                end
                PH_META_LEN: begin
                    varlen = {varlen[24:0], b[6:0]};
                    if (!b[7]) begin
                        payload = varlen;
                        shift = '0;
                        if (payload != 0) begin
                            phase = PH_META_DATA;
                        end else if (is_text()) begin
                            r = blank_event(K_TEXT);
                            r.meta_type = cur_meta;
                            r.last = 1'b1;
                            emit(n, r);
                            end_event(n);
                        end else begin
                            close_meta(n);
                        end
                    end
                end
                PH_META_DATA: begin
                    payload--;
                    shift = {shift[31:0], b};
                    if (is_text()) begin
                        r = blank_event(K_TEXT);
                        r.first_data = b;
                        r.has_data = 1'b1;
                        r.meta_type = cur_meta;
                        r.last = (payload == 0);
                        emit(n, r);
                        if (payload == 0) end_event(n);
                    end else if (payload == 0) begin
                        close_meta(n);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_event(t_res got);
            t_res want;
            n_events++;
            if (pending.size() == 0) begin
                $error("event kind %0d with no event predicted", got.kind);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind != want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.channel != want.channel) begin
                $error("channel: expected %0d, got %0d", want.channel, got.channel);
                errors++;
            end
            if (got.first_data != want.first_data) begin
                $error("first_data: expected %0h, got %0h", want.first_data, got.first_data);
                errors++;
            end
            if (got.second_data != want.second_data) begin
                $error("second_data: expected %0h, got %0h",
                       want.second_data, got.second_data);
                errors++;
            end
            if (got.has_data != want.has_data) begin
                $error("has_data: expected %0b, got %0b", want.has_data, got.has_data);
                errors++;
            end
            if (got.meta_value != want.meta_value) begin
                $error("meta_value: expected %0h, got %0h", want.meta_value, got.meta_value);
                errors++;
            end
            if (got.meta_type != want.meta_type) begin
                $error("meta_type: expected %0h, got %0h", want.meta_type, got.meta_type);
                errors++;
            end
            if (got.event_ticks != want.event_ticks) begin
                $error("event_ticks: expected %0d, got %0d",
                       want.event_ticks, got.event_ticks);
                errors++;
            end
            if (got.error_code != want.error_code) begin
                $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
                errors++;
            end
            if (got.last != want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [4:0] i_cfg_wdata;

    mtcp_byte_if  byte_ch();
    mtcp_event_if event_ch();

    midi_track_chunk_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (byte_ch),
        .o_event     (event_ch)
    );

    event_scoreboard sb = new();
    logic [8:0] stim[$];
    bit calm;
    int idle_cycles;
    int track_total;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.chunk_start = 1'b0;
        event_ch.ready = 1'b0;
    end

    function automatic int gap_len();
        int p;
        if (calm) return 0;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Event sink: alternate stall and accept stretches.
    initial begin
        int g;
        int run;
        @(posedge i_rst_n);
        forever begin
            g = gap_len();
            repeat (g) begin
                @(negedge i_clk);
                event_ch.ready = 1'b0;
            end
            run = $urandom_range(1, 20);
            repeat (run) begin
                @(negedge i_clk);
                event_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n) begin
            if (i_cfg_we) sb.set_filter(i_cfg_wdata);
            if (byte_ch.valid && byte_ch.ready)
                sb.note_byte(byte_ch.data_byte, byte_ch.chunk_start);
            if (event_ch.valid && event_ch.ready) begin
                got.kind = t_kind'(event_ch.kind);
                got.channel = event_ch.channel;
                got.first_data = event_ch.first_data;
                got.second_data = event_ch.second_data;
                got.has_data = event_ch.has_data;
                got.meta_value = event_ch.meta_value;
                got.meta_type = event_ch.meta_type;
                got.event_ticks = event_ch.event_ticks;
                got.error_code = t_err'(event_ch.error_code);
                got.last = event_ch.last;
                sb.check_event(got);
            end
            if ((byte_ch.valid && byte_ch.ready) || (event_ch.valid && event_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog: no handshake for %0d cycles", IdleLimit);
                $display("CHECK FAILED");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    task automatic send_byte(logic [7:0] b, logic cs);
        int g;
        g = gap_len();
        repeat (g) begin
            @(negedge i_clk);
            byte_ch.valid = 1'b0;
            byte_ch.data_byte = 8'($urandom_range(0, 255));
            byte_ch.chunk_start = 1'($urandom_range(0, 1));
        end
        @(negedge i_clk);
        byte_ch.valid = 1'b1;
        byte_ch.data_byte = b;
        byte_ch.chunk_start = cs;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    task automatic send_all();
        logic [8:0] w;
        while (stim.size() != 0) begin
            w = stim.pop_front();
            send_byte(w[7:0], w[8]);
        end
        @(negedge i_clk);
        byte_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_filter(logic [4:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic void put_varlen(ref logic [7:0] q[$], input int unsigned v);
        logic [7:0] grp[$];
        grp.push_front({1'b0, v[6:0]});
        v = v >> 7;
        while (v != 0) begin
            grp.push_front({1'b1, v[6:0]});
            v = v >> 7;
        end
        foreach (grp[i]) q.push_back(grp[i]);
    endfunction

    // Queue one chunk: tag, length adjusted by len_adj, body.
    function automatic void add_chunk(logic [7:0] body[$], int len_adj, bit bad_tag);
        logic [31:0] tag;
        logic [31:0] len;
        tag = TagMtrk;
        if (bad_tag) tag[8 * $urandom_range(0, 3) +: 8] ^= 8'd1 << $urandom_range(0, 7);
        len = 32'(body.size() + len_adj);
        stim.push_back({1'b1, tag[31:24]});
        stim.push_back({1'b0, tag[23:16]});
        stim.push_back({1'b0, tag[15:8]});
        stim.push_back({1'b0, tag[7:0]});
        for (int i = 3; i >= 0; i--) stim.push_back({1'b0, len[8 * i +: 8]});
        foreach (body[i]) stim.push_back({1'b0, body[i]});
    endfunction

    function automatic logic [7:0] data7();
        if ($urandom_range(0, 19) == 0) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic void random_track(bit clean);
        logic [7:0] body[$];
        logic [7:0] st;
        logic [7:0] mt;
        int n_ev;
        int p;
        int len;
        bit have_rs;
        bit sx_cont;
        have_rs = 0;
        sx_cont = 0;
        n_ev = $urandom_range(2, 12);
        for (int e = 0; e < n_ev; e++) begin
            p = $urandom_range(0, 99);
            if (p < 10) begin
                // overlong delta wraps the accumulator
                repeat ($urandom_range(4, 6)) body.push_back(8'($urandom_range(128, 255)));
                body.push_back(8'($urandom_range(0, 127)));
            end else if (p < 60) begin
                put_varlen(body, $urandom_range(0, 3000));
            end else begin
                body.push_back(8'h00);
            end
            p = $urandom_range(0, 99);
            if (sx_cont) begin
                body.push_back(StEscape);
                len = $urandom_range(1, 4);
                put_varlen(body, len);
                repeat (len - 1) body.push_back(8'($urandom_range(0, 127)));
                body.push_back(($urandom_range(0, 3) != 0) ? StEscape : 8'h11);
                sx_cont = (body[body.size() - 1] != StEscape);
            end else if (p < 45) begin
                if (!(have_rs && $urandom_range(0, 2) == 0)) begin
                    st = 8'(8'h80 + $urandom_range(0, 111));
                    body.push_back(st);
                end
                body.push_back(data7());
                if (st[7:5] != 3'b110) body.push_back(data7());
                have_rs = 1;
            end else if (p < 60) begin
                body.push_back(($urandom_range(0, 4) == 0) ? StEscape : StSysex);
                len = $urandom_range(0, 5);
                put_varlen(body, len);
                repeat (len) body.push_back(8'($urandom_range(0, 127)));
                if (len > 0 && $urandom_range(0, 2) != 0) body[body.size() - 1] = StEscape;
                sx_cont = (len == 0) || (body[body.size() - 1] != StEscape);
                have_rs = 0;
            end else if (p < 92 || clean) begin
                p = $urandom_range(0, 11);
                case (p)
                    0: mt = MtSeqNum;
                    1: mt = MtEot;
                    2: mt = MtTempo;
                    3: mt = MtSmpte;
                    4: mt = MtTimeSig;
                    5: mt = MtKeySig;
                    6, 7, 8: mt = 8'($urandom_range(1, 15));
                    9: mt = 8'h20;
                    10: mt = 8'h7f;
                    default: mt = 8'($urandom_range(0, 255));
                endcase
                case (mt)
                    MtSeqNum, MtKeySig: len = 2;
                    MtEot: len = 0;
                    MtTempo: len = 3;
                    MtSmpte: len = 5;
                    MtTimeSig: len = 4;
                    default: len = $urandom_range(0, 6);
                endcase
                if ($urandom_range(0, 4) == 0) len = $urandom_range(0, 7);
                body.push_back(StMeta);
                body.push_back(mt);
                if ($urandom_range(0, 7) == 0) begin
                    body.push_back(8'h80);
                    body.push_back(8'(len));
                end else begin
                    put_varlen(body, len);
                end
                repeat (len) body.push_back(8'($urandom_range(0, 255)));
                have_rs = 0;
            end else begin
                p = $urandom_range(0, 1);
                if (p == 0) body.push_back(($urandom_range(0, 1) != 0) ?
                                           8'(8'hf1 + $urandom_range(0, 5)) :
                                           8'(8'hf8 + $urandom_range(0, 6)));
                else body.push_back(8'($urandom_range(0, 255)));
            end
        end
        p = $urandom_range(0, 99);
        add_chunk(body, (p < 85) ? 0 : $urandom_range(0, 6) - 3,
                  !clean && $urandom_range(0, 19) == 0);
        // stray bytes after the chunk are ignored
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) stim.push_back({1'b0, 8'($urandom_range(0, 255))});
        track_total++;
    endfunction

    task automatic directed_part();
        logic [7:0] body[$];
        calm = 1;
        body = '{8'h00, 8'h90, 8'h3c, 8'h64, 8'h00, 8'h3c, 8'h00,
                 8'h05, 8'h80, 8'h3c, 8'h40, 8'h00, 8'ha1, 8'h10, 8'h20,
                 8'h00, 8'hb2, 8'h07, 8'h7f, 8'h00, 8'hc3, 8'h05,
                 8'h00, 8'hdf, 8'h40, 8'h00, 8'he0, 8'h00, 8'h40,
                 8'h00, 8'hf0, 8'h02, 8'h01, 8'hf7,
                 8'h00, 8'hff, 8'h00, 8'h02, 8'hff, 8'hff,
                 8'h00, 8'hff, 8'h03, 8'h02, 8'h41, 8'h42,
                 8'h00, 8'hff, 8'h01, 8'h00,
                 8'h7f, 8'hff, 8'h51, 8'h03, 8'h07, 8'ha1, 8'h20,
                 8'h00, 8'hff, 8'h54, 8'h05, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                 8'h00, 8'hff, 8'h58, 8'h04, 8'h04, 8'h02, 8'h18, 8'h08,
                 8'h00, 8'hff, 8'h59, 8'h02, 8'hfd, 8'h01,
                 8'h00, 8'hff, 8'h7f, 8'h01, 8'h55,
                 8'h00, 8'hff, 8'h2f, 8'h00};
        add_chunk(body, 0, 0);
        body = '{};
        add_chunk(body, 0, 1);
        add_chunk(body, 0, 0);
        body = '{8'h00, 8'hf5};
        add_chunk(body, 0, 0);
        body = '{8'h00, 8'h40};
        add_chunk(body, 0, 0);
        body = '{8'h00, 8'hff, 8'h2f, 8'h00, 8'h00, 8'h40, 8'h40};
        add_chunk(body, 0, 0);
        body = '{8'h00, 8'hf0, 8'h01, 8'h11, 8'h00, 8'h90, 8'h01, 8'h01};
        add_chunk(body, 0, 0);
        body = '{8'h00, 8'hf0, 8'h00, 8'h00, 8'hf7, 8'h00};
        add_chunk(body, 0, 0);
        body = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h90, 8'h3c, 8'h64};
        add_chunk(body, -3, 0);
        send_all();
        calm = 0;
    endtask

    initial begin
        logic [4:0] filters[$];
        int start_bytes;
        calm = 0;
        idle_cycles = 0;
        track_total = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_filter(5'd0);
        directed_part();
        filters = '{5'd0, 5'd1, 5'd16, 5'd31, 5'($urandom_range(2, 15)), 5'd17, 5'd0};
        foreach (filters[i]) begin
            write_filter(filters[i]);
            start_bytes = sb.n_bytes;
            while (sb.n_bytes - start_bytes < 140) begin
                calm = ($urandom_range(0, 7) == 0);
                random_track($urandom_range(0, 3) != 0);
                send_all();
            end
        end
        calm = 0;
        drain();
        repeat (20) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d predicted events never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("run covered %0d bytes in %0d random chunks plus directed chunks,",
                 sb.n_bytes, track_total);
        $display("%0d events checked over %0d channel filter settings",
                 sb.n_events, filters.size() + 1);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
